FILE: src/ucr_pkg.sv
// ----------------------------------------------------------------------------
// Use-count replacement cache package
// Word types, cell token and update types shared by the cache modules.
// ----------------------------------------------------------------------------
package ucr_pkg;

  localparam int unsigned TAG_W   = 16;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned BEST_W  = COUNT_W + 1;
  localparam int unsigned SLOT_W  = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [BEST_W-1:0]  BEST_INIT = {1'b1, {COUNT_W{1'b0}}};

  typedef struct packed {
    logic [TAG_W-1:0] access_id;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted_valid;
    logic [TAG_W-1:0]  evicted_id;
  } out_word_t;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  id;
    logic              hit;
    logic [BEST_W-1:0] best;
    logic              best_valid;
    logic [TAG_W-1:0]  best_tag;
  } token_t;

  typedef struct packed {
    logic             we;
    logic             hit;
    logic [TAG_W-1:0] id;
  } upd_t;

endpackage

FILE: src/ucr_in_if.sv
// ----------------------------------------------------------------------------
// Access channel
// Valid/ready channel carrying one access word.
// ----------------------------------------------------------------------------
interface ucr_in_if;
  import ucr_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/ucr_out_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface ucr_out_if;
  import ucr_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: src/ucr_cell.sv
// ----------------------------------------------------------------------------
// Cache cell
// One slot of the tag store. Updates the lookup token passing through it
// with its hit and victim candidacy, and applies the broadcast update.
// ----------------------------------------------------------------------------
module ucr_cell #(
  parameter int unsigned ENTRIES = 8,
  parameter int unsigned INDEX   = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ucr_pkg::token_t            tok_i,
  input  logic [$clog2(ENTRIES)-1:0] tok_hit_idx_i,
  input  logic [$clog2(ENTRIES)-1:0] tok_best_idx_i,
  output ucr_pkg::token_t            tok_o,
  output logic [$clog2(ENTRIES)-1:0] tok_hit_idx_o,
  output logic [$clog2(ENTRIES)-1:0] tok_best_idx_o,
  input  ucr_pkg::upd_t              upd_i,
  input  logic [$clog2(ENTRIES)-1:0] upd_idx_i
);
  import ucr_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic               valid_q, valid_d;
  logic [TAG_W-1:0]   tag_q, tag_d;
  logic [COUNT_W-1:0] count_q, count_d;

  token_t             tok_q, tok_d;
  logic [IDX_W-1:0]   hit_idx_q, hit_idx_d;
  logic [IDX_W-1:0]   best_idx_q, best_idx_d;

  logic [BEST_W-1:0]  eff_count;
  logic               match;
  logic               better;
  logic               sel;

  assign eff_count = valid_q ? {1'b0, count_q} : '0;
  assign match     = valid_q && (tag_q == tok_i.id) && !tok_i.hit;
  assign better    = eff_count < tok_i.best;
  assign sel       = upd_i.we && (upd_idx_i == MY_IDX);

  always_comb begin
    tok_d      = tok_i;
    hit_idx_d  = tok_hit_idx_i;
    best_idx_d = tok_best_idx_i;
    if (match) begin
      tok_d.hit = 1'b1;
      hit_idx_d = MY_IDX;
    end
    if (better) begin
      tok_d.best       = eff_count;
      tok_d.best_valid = valid_q;
      tok_d.best_tag   = tag_q;
      best_idx_d       = MY_IDX;
    end
  end

  always_comb begin
    valid_d = valid_q;
    tag_d   = tag_q;
    count_d = count_q;
    if (sel) begin
      if (upd_i.hit) begin
        if (count_q != COUNT_MAX) begin
          count_d = count_q + COUNT_W'(1);
        end
      end else begin
        valid_d = 1'b1;
        tag_d   = upd_i.id;
        count_d = COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      tag_q      <= '0;
      count_q    <= '0;
      tok_q      <= '0;
      hit_idx_q  <= '0;
      best_idx_q <= '0;
    end else begin
      valid_q    <= valid_d;
      tag_q      <= tag_d;
      count_q    <= count_d;
      tok_q      <= tok_d;
      hit_idx_q  <= hit_idx_d;
      best_idx_q <= best_idx_d;
    end
  end

  assign tok_o          = tok_q;
  assign tok_hit_idx_o  = hit_idx_q;
  assign tok_best_idx_o = best_idx_q;

endmodule

FILE: src/use_count_replacement_cache.sv
// Each lookup token is registered in every cell in turn before its result is queued.
// Only one access is in flight: the next is taken after the lookup token walks
// the row of cells one cell per cycle and the chosen slot is updated.
// A finished result waits in a two-word output queue while the next access is taken.
// Reset clears every slot, the tokens in the row of cells and the output queue.
// ----------------------------------------------------------------------------
// Use-count replacement cache
// Fully associative tag store built as a row of cells; hits bump a saturating
// use count, misses replace the lowest-count slot.
// ----------------------------------------------------------------------------
module use_count_replacement_cache #(
  parameter int unsigned ENTRIES = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ucr_in_if.sink      in_i,
  ucr_out_if.source   out_o
);
  import ucr_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);

  token_t           tok       [ENTRIES+1];
  logic [IDX_W-1:0] hit_idx   [ENTRIES+1];
  logic [IDX_W-1:0] best_idx  [ENTRIES+1];

  upd_t             upd;
  logic [IDX_W-1:0] upd_idx;

  logic             busy_q, busy_d;
  logic             q0_valid_q, q0_valid_d;
  logic             q1_valid_q, q1_valid_d;
  out_word_t        q0_q, q0_d;
  out_word_t        q1_q, q1_d;

  token_t           last;
  out_word_t        res;
  logic             accept;
  logic             push;
  logic             pop;

  assign in_i.ready = !busy_q && !q1_valid_q;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    tok[0].valid      = accept;
    tok[0].id         = in_i.data.access_id;
    tok[0].hit        = 1'b0;
    tok[0].best       = BEST_INIT;
    tok[0].best_valid = 1'b0;
    tok[0].best_tag   = '0;
    hit_idx[0]        = '0;
    best_idx[0]       = '0;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    ucr_cell #(
      .ENTRIES (ENTRIES),
      .INDEX   (g)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .tok_i          (tok[g]),
      .tok_hit_idx_i  (hit_idx[g]),
      .tok_best_idx_i (best_idx[g]),
      .tok_o          (tok[g+1]),
      .tok_hit_idx_o  (hit_idx[g+1]),
      .tok_best_idx_o (best_idx[g+1]),
      .upd_i          (upd),
      .upd_idx_i      (upd_idx)
    );
  end

  assign last = tok[ENTRIES];
  assign push = last.valid;
  assign pop  = q0_valid_q && out_o.ready;

  always_comb begin
    upd.we  = last.valid;
    upd.hit = last.hit;
    upd.id  = last.id;
    upd_idx = last.hit ? hit_idx[ENTRIES] : best_idx[ENTRIES];

    res.hit = last.hit;
    if (last.hit) begin
      res.slot          = SLOT_W'(hit_idx[ENTRIES]);
      res.evicted_valid = 1'b0;
      res.evicted_id    = '0;
    end else begin
      res.slot          = SLOT_W'(best_idx[ENTRIES]);
      res.evicted_valid = last.best_valid;
      res.evicted_id    = last.best_valid ? last.best_tag : '0;
    end
  end

  always_comb begin
    busy_d     = busy_q;
    q0_valid_d = q0_valid_q;
    q1_valid_d = q1_valid_q;
    q0_d       = q0_q;
    q1_d       = q1_q;
    if (accept) begin
      busy_d = 1'b1;
    end
    if (push) begin
      busy_d = 1'b0;
    end
    if (pop) begin
      q0_valid_d = q1_valid_q;
      q0_d       = q1_q;
      q1_valid_d = 1'b0;
    end
    if (push) begin
      if (!q0_valid_d) begin
        q0_valid_d = 1'b1;
        q0_d       = res;
      end else begin
        q1_valid_d = 1'b1;
        q1_d       = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      q0_valid_q <= 1'b0;
      q1_valid_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      q0_valid_q <= q0_valid_d;
      q1_valid_q <= q1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q <= q0_d;
    q1_q <= q1_d;
  end

  assign out_o.valid = q0_valid_q;
  assign out_o.data  = q0_q;

endmodule

FILE: src/ucr_checker.sv
// ----------------------------------------------------------------------------
// Use-count replacement cache checker
// Port-level properties of the cache, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ucr_checker #(
  parameter int unsigned ENTRIES = 8
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_hit_i,
  input logic        out_evicted_valid_i,
  input logic [15:0] out_evicted_id_i
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("Result word dropped before it was taken.");

  a_one_in_flight : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("Access taken while a lookup was still in flight.");

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ##(ENTRIES + 1) out_valid_i)
    else $error("Result word missing after a full lookup pass.");

  a_hit_no_evict : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_hit_i |-> !out_evicted_valid_i)
    else $error("Hit result reports an eviction.");

  a_evict_id_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_evicted_valid_i |-> out_evicted_id_i == 16'h0000)
    else $error("Evicted identifier set without an eviction.");

endmodule

bind use_count_replacement_cache ucr_checker #(
  .ENTRIES (ENTRIES)
) u_ucr_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (in_i.valid),
  .in_ready_i          (in_i.ready),
  .out_valid_i         (out_o.valid),
  .out_ready_i         (out_o.ready),
  .out_hit_i           (out_o.data.hit),
  .out_evicted_valid_i (out_o.data.evicted_valid),
  .out_evicted_id_i    (out_o.data.evicted_id)
);
